// ===== design/act_pkg.sv =====
// ----------------------------------------------------------------------------
// act_pkg
// Shared types, character codes, token kinds and classifier functions for the
// assembly character tokenizer.
// ----------------------------------------------------------------------------
package act_pkg;

    localparam int LINE_WIDTH_DEF   = 16;
    localparam int COLUMN_WIDTH_DEF = 16;
    localparam int LENGTH_WIDTH_DEF = 8;

    localparam int CFG_DATA_W = 16;
    localparam int KIND_W     = 4;

    // configuration register indexes
    localparam logic CFG_FIRST_LINE   = 1'b0;
    localparam logic CFG_FIRST_COLUMN = 1'b1;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_END     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 4'd1;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_COLON   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd6;
    localparam logic [KIND_W-1:0] KIND_REG     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_FPREG   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DIR     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_INT     = 4'd11;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 4'd12;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_XU     = 8'h58;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_REG     = 4'd2,
        M_DIR     = 4'd3,
        M_IDENT   = 4'd4,
        M_MINUS   = 4'd5,
        M_ZERO    = 4'd6,
        M_DEC     = 4'd7,
        M_HEXPFX  = 4'd8,
        M_HEX     = 4'd9
    } t_scan_mode;

    // queue write request: slot 1 is only valid together with slot 0
    typedef struct packed {
        logic v0;
        logic v1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

endpackage

// ===== design/act_scan.sv =====
// ----------------------------------------------------------------------------
// act_scan
// Lexer state and one-character step: updates mode, counters and pending
// token, and produces up to two compacted token descriptors.
// ----------------------------------------------------------------------------
module act_scan #(
    parameter int LINE_WIDTH   = act_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = act_pkg::COLUMN_WIDTH_DEF,
    parameter int LENGTH_WIDTH = act_pkg::LENGTH_WIDTH_DEF,
    localparam int TOK_W = act_pkg::KIND_W + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [7:0]                    i_char,
    input  logic                          i_end,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [act_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output act_pkg::t_push                o_push,
    output logic [TOK_W-1:0]              o_tok0,   // {last, length, column, line, kind}
    output logic [TOK_W-1:0]              o_tok1
);

    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
    localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = {LENGTH_WIDTH{1'b1}};

    act_pkg::t_scan_mode        r_mode, n_mode;
    logic [LINE_WIDTH-1:0]      r_line, n_line;
    logic [COLUMN_WIDTH-1:0]    r_col, n_col;
    logic [LINE_WIDTH-1:0]      r_sline, n_sline;
    logic [COLUMN_WIDTH-1:0]    r_scol, n_scol;
    logic [LENGTH_WIDTH-1:0]    r_plen, n_plen;
    logic                       r_dot, n_dot;
    logic [1:0]                 r_frp, n_frp;

    logic                       w_ext_ok;
    act_pkg::t_scan_mode        w_ext_mode;
    logic                       w_ext_dot;
    logic [1:0]                 w_ext_frp;
    logic                       w_active;
    logic                       w_bad_dot;
    logic                       w_do_flush;
    logic                       w_run_idle;
    logic [act_pkg::KIND_W-1:0] w_flush_kind;
    logic                       w_starts;
    act_pkg::t_scan_mode        w_start_mode;
    logic                       w_punct;
    logic [act_pkg::KIND_W-1:0] w_punct_kind;
    logic                       w_b_valid;
    logic [TOK_W-2:0]           w_tok_a, w_tok_b;
    logic [31:0]                w_cfg32;
    logic [LINE_WIDTH-1:0]      w_cfg_line;
    logic [COLUMN_WIDTH-1:0]    w_cfg_col;

    // extension of the pending token
    always_comb begin
        w_ext_ok   = 1'b0;
        w_ext_mode = r_mode;
        w_ext_dot  = r_dot;
        w_ext_frp  = r_frp;
        case (r_mode)
            act_pkg::M_REG: begin
                w_ext_ok = act_pkg::is_word(i_char);
                if (r_plen == LENGTH_WIDTH'(1) && i_char == act_pkg::CH_F) begin
                    w_ext_frp = 2'd1;
                end else if (r_frp == 2'd1 && r_plen == LENGTH_WIDTH'(2)
                             && act_pkg::is_digit(i_char)) begin
                    w_ext_frp = 2'd2;
                end
            end
            act_pkg::M_DIR: w_ext_ok = act_pkg::is_word(i_char);
            act_pkg::M_IDENT: w_ext_ok = act_pkg::is_word(i_char) || (i_char == act_pkg::CH_DOT);
            act_pkg::M_MINUS: begin
                w_ext_ok   = act_pkg::is_digit(i_char);
                w_ext_mode = (i_char == act_pkg::CH_ZERO) ? act_pkg::M_ZERO : act_pkg::M_DEC;
            end
            act_pkg::M_ZERO: begin
                if (i_char == act_pkg::CH_X || i_char == act_pkg::CH_XU) begin
                    w_ext_ok   = 1'b1;
                    w_ext_mode = act_pkg::M_HEXPFX;
                end else if (act_pkg::is_digit(i_char)) begin
                    w_ext_ok   = 1'b1;
                    w_ext_mode = act_pkg::M_DEC;
                end else if (i_char == act_pkg::CH_DOT) begin
                    w_ext_ok   = 1'b1;
                    w_ext_mode = act_pkg::M_DEC;
                    w_ext_dot  = 1'b1;
                end
            end
            act_pkg::M_DEC: begin
                if (i_char == act_pkg::CH_DOT) begin
                    w_ext_ok  = !r_dot;
                    w_ext_dot = 1'b1;
                end else begin
                    w_ext_ok = act_pkg::is_digit(i_char);
                end
            end
            act_pkg::M_HEXPFX, act_pkg::M_HEX: begin
                w_ext_ok   = act_pkg::is_hex(i_char);
                w_ext_mode = act_pkg::M_HEX;
            end
            default: w_ext_ok = 1'b0;
        endcase
    end

    // kind of the pending token when it is closed
    always_comb begin
        case (r_mode)
            act_pkg::M_REG:
                w_flush_kind = (r_frp == 2'd2) ? act_pkg::KIND_FPREG : act_pkg::KIND_REG;
            act_pkg::M_DIR:
                w_flush_kind = (r_plen >= LENGTH_WIDTH'(2)) ? act_pkg::KIND_DIR
                                                             : act_pkg::KIND_UNKNOWN;
            act_pkg::M_IDENT: w_flush_kind = act_pkg::KIND_IDENT;
            act_pkg::M_ZERO, act_pkg::M_HEX: w_flush_kind = act_pkg::KIND_INT;
            act_pkg::M_DEC:
                w_flush_kind = w_bad_dot ? act_pkg::KIND_UNKNOWN
                             : (r_dot ? act_pkg::KIND_FLOAT : act_pkg::KIND_INT);
            default: w_flush_kind = act_pkg::KIND_UNKNOWN;
        endcase
    end

    // classification of a character seen from idle
    always_comb begin
        w_starts     = 1'b1;
        w_start_mode = act_pkg::M_IDENT;
        w_punct      = 1'b0;
        w_punct_kind = act_pkg::KIND_UNKNOWN;
        if (act_pkg::is_blank(i_char) || i_char == act_pkg::CH_HASH) begin
            w_starts = 1'b0;
        end else if (i_char == act_pkg::CH_DOLLAR) begin
            w_start_mode = act_pkg::M_REG;
        end else if (i_char == act_pkg::CH_DOT) begin
            w_start_mode = act_pkg::M_DIR;
        end else if (act_pkg::is_alpha(i_char) || i_char == act_pkg::CH_UNDER) begin
            w_start_mode = act_pkg::M_IDENT;
        end else if (i_char == act_pkg::CH_MINUS) begin
            w_start_mode = act_pkg::M_MINUS;
        end else if (i_char == act_pkg::CH_ZERO) begin
            w_start_mode = act_pkg::M_ZERO;
        end else if (act_pkg::is_digit(i_char)) begin
            w_start_mode = act_pkg::M_DEC;
        end else begin
            w_starts = 1'b0;
            w_punct  = 1'b1;
            case (i_char)
                act_pkg::CH_NL:    w_punct_kind = act_pkg::KIND_NEWLINE;
                act_pkg::CH_COMMA: w_punct_kind = act_pkg::KIND_COMMA;
                act_pkg::CH_COLON: w_punct_kind = act_pkg::KIND_COLON;
                act_pkg::CH_LPAR:  w_punct_kind = act_pkg::KIND_LPAREN;
                act_pkg::CH_RPAR:  w_punct_kind = act_pkg::KIND_RPAREN;
                default:           w_punct_kind = act_pkg::KIND_UNKNOWN;
            endcase
        end
    end

    // the byte beside an end of source is ignored, so it never marks a second dot
    assign w_active   = (r_mode != act_pkg::M_IDLE) && (r_mode != act_pkg::M_COMMENT);
    assign w_bad_dot  = !i_end && (r_mode == act_pkg::M_DEC) && (i_char == act_pkg::CH_DOT)
                      && r_dot;
    assign w_do_flush = w_active && (i_end || !w_ext_ok);
    assign w_run_idle = !i_end && ((r_mode == act_pkg::M_IDLE)
                      || (r_mode == act_pkg::M_COMMENT && i_char == act_pkg::CH_NL)
                      || (w_active && !w_ext_ok));
    assign w_b_valid  = i_end || (w_run_idle && w_punct);

    // configuration values clipped to counter width
    assign w_cfg32    = 32'(i_cfg_data);
    assign w_cfg_line = (w_cfg32 > 32'(LINE_MAX)) ? LINE_MAX : w_cfg32[LINE_WIDTH-1:0];
    assign w_cfg_col  = (w_cfg32 > 32'(COL_MAX)) ? COL_MAX : w_cfg32[COLUMN_WIDTH-1:0];

    always_comb begin
        n_mode  = r_mode;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_plen  = r_plen;
        n_dot   = r_dot;
        n_frp   = r_frp;
        n_line  = r_line;
        n_col   = r_col;
        if (i_end) begin
            n_mode = act_pkg::M_IDLE;
            n_plen = '0;
            n_dot  = 1'b0;
            n_frp  = 2'd0;
        end else if (w_run_idle) begin
            n_plen = '0;
            n_dot  = 1'b0;
            n_frp  = 2'd0;
            if (i_char == act_pkg::CH_HASH) begin
                n_mode = act_pkg::M_COMMENT;
            end else if (w_starts) begin
                n_mode  = w_start_mode;
                n_sline = r_line;
                n_scol  = r_col;
                n_plen  = LENGTH_WIDTH'(1);
            end else begin
                n_mode = act_pkg::M_IDLE;
            end
        end else if (w_active) begin
            n_mode = w_ext_mode;
            n_dot  = w_ext_dot;
            n_frp  = w_ext_frp;
            if (r_plen != LEN_MAX) begin
                n_plen = r_plen + LENGTH_WIDTH'(1);
            end
        end
        // every source character advances the position, saturating at the counter maximum
        if (!i_end) begin
            if (i_char == act_pkg::CH_NL) begin
                n_col = '0;
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_WIDTH'(1);
                end
            end else if (r_col != COL_MAX) begin
                n_col = r_col + COLUMN_WIDTH'(1);
            end
        end
    end

    // descriptors: A is the closed pending token, B the end or single-char token
    assign w_tok_a = {r_plen, r_scol, r_sline, w_flush_kind};
    assign w_tok_b = i_end ? {LENGTH_WIDTH'(0), r_col, r_line, act_pkg::KIND_END}
                           : {LENGTH_WIDTH'(1), r_col, r_line, w_punct_kind};

    always_comb begin
        o_push.v0 = i_step && (w_do_flush || w_b_valid);
        o_push.v1 = i_step && w_do_flush && w_b_valid;
        o_tok0    = w_do_flush ? {!w_b_valid, w_tok_a} : {1'b1, w_tok_b};
        o_tok1    = {1'b1, w_tok_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= act_pkg::M_IDLE;
            r_line  <= LINE_WIDTH'(1);
            r_col   <= '0;
            r_sline <= '0;
            r_scol  <= '0;
            r_plen  <= '0;
            r_dot   <= 1'b0;
            r_frp   <= 2'd0;
        end else begin
            if (i_step) begin
                r_mode  <= n_mode;
                r_sline <= n_sline;
                r_scol  <= n_scol;
                r_plen  <= n_plen;
                r_dot   <= n_dot;
                r_frp   <= n_frp;
                r_line  <= n_line;
                r_col   <= n_col;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == act_pkg::CFG_FIRST_LINE) begin
                    r_line <= w_cfg_line;
                end else begin
                    r_col <= w_cfg_col;
                end
            end
        end
    end

endmodule

// ===== design/act_queue.sv =====
// ----------------------------------------------------------------------------
// act_queue
// Four-entry result queue: takes up to two descriptors a cycle, hands out one.
// ----------------------------------------------------------------------------
module act_queue #(
    parameter int DATA_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  act_pkg::t_push        i_push,
    input  logic [DATA_W-1:0]     i_d0,
    input  logic [DATA_W-1:0]     i_d1,
    output logic                  o_room,   // at least two free entries
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_W-1:0]     o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_count, n_count;
    logic              w_pop;
    logic [PTR_W-1:0]  w_wr_ptr1;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign o_room    = (r_count <= (PTR_W+1)'(DEPTH - 2));
    assign w_pop     = o_valid && i_ready;
    assign w_wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_count = r_count + (PTR_W+1)'(i_push.v0) + (PTR_W+1)'(i_push.v1)
                - (PTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_d0;
        end
        if (i_push.v1) begin
            r_mem[w_wr_ptr1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.v0) + PTR_W'(i_push.v1);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== design/assembly_char_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// assembly_char_tokenizer_top
// Assembly source lexer: one byte per request in, token descriptors out.
// ----------------------------------------------------------------------------
// Path: a request that completes a token is held in the input register, is stepped
//   through the scanner and writes the token into the result queue that drives the output.
// Throughput: one byte per cycle while the four-entry result queue holds at most
//   two tokens; above that the input stalls (two-token bytes or output stalls).
// Reset (synchronous, active low): scanner idle, line 1, column 0, queue empty.
// Configuration writes load the line or column counter directly.
module assembly_char_tokenizer_top #(
    parameter int LINE_WIDTH   = act_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = act_pkg::COLUMN_WIDTH_DEF,
    parameter int LENGTH_WIDTH = act_pkg::LENGTH_WIDTH_DEF,
    localparam int DATA_W  = act_pkg::KIND_W + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH,
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // source_char
    input  logic                           i_s_axis_tuser,   // end_of_source
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // token_kind, token_line, token_column, token_length, zero fill
    output logic [TDATA_W-1:0]             o_m_axis_tdata,
    output logic                           o_m_axis_tlast,   // last_of_run
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [act_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TOK_W = DATA_W + 1;

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_end;
    logic              w_room;
    logic              w_step;
    logic              w_take;
    act_pkg::t_push    w_push;
    logic [TOK_W-1:0]  w_tok0, w_tok1, w_qdata;

    assign w_step          = r_in_valid && w_room;
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_take || (r_in_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tuser;
        end
    end

    act_scan #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_char      (r_in_char),
        .i_end       (r_in_end),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_tok0      (w_tok0),
        .o_tok1      (w_tok1)
    );

    act_queue #(
        .DATA_W (TOK_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_d0    (w_tok0),
        .i_d1    (w_tok1),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_qdata)
    );

    assign o_m_axis_tdata = TDATA_W'(w_qdata[DATA_W-1:0]);
    assign o_m_axis_tlast = w_qdata[DATA_W];

endmodule
